### rtl/pid_controller_step_assert.svh
// Assertion macros for the PID step block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define PIDC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidc: same-cycle check failed");

// Consequence holds in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidc: next-cycle check failed");

`endif

### rtl/pidc_pkg.sv
// Shared types and constants for the PID step block.
// No dependencies; every other file but the assertion header imports this package.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 24;

  localparam int DATA_W = 32;
  localparam int TIME_W = 24;
  localparam int ADDR_W = 5;
  // magnitude of a 33 bit signed difference
  localparam int MAG_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MAG_W;
  // dividend magnitude stays below 2^57
  localparam int QUO_W  = 57;
  localparam int DEN_W  = TIME_W + 1;

  localparam logic [MAG_W-1:0] USEC_PER_S    = 33'd1000000;
  localparam logic [DEN_W-1:0] TWO_MEGA      = 25'd2000000;
  localparam logic [QUO_W-1:0] HALF_TWO_MEGA = 57'd1000000;

  typedef enum logic [2:0] {
    REG_SETPOINT,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_OUT_MAX,
    REG_OUT_MIN,
    REG_INTEG_LIMIT,
    REG_DERIV_MODE
  } reg_idx_t;

  typedef enum logic [1:0] {
    DMODE_ERR,
    DMODE_FILT,
    DMODE_MEAS,
    DMODE_EXT
  } dmode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
    logic [DATA_W-2:0]        integ_limit;
    dmode_t                   deriv_mode;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_I_MUL,
    ST_I_DIV,
    ST_D_MUL,
    ST_D_DIV,
    ST_F_MUL,
    ST_F_DIV,
    ST_G_D,
    ST_G_P,
    ST_G_I,
    ST_SUM,
    ST_OUT
  } state_t;

endpackage

### rtl/pidc_if.sv
// Valid/ready channel interfaces for the PID step block.
// Depends on pidc_pkg for field widths.
`timescale 1ns / 1ps

interface pidc_in_if import pidc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [DATA_W-1:0] feedback;
  logic [TIME_W-1:0]        elapsed_us;
  logic [TIME_W-1:0]        filter_tau_us;
  logic signed [DATA_W-1:0] measured_deriv;

  modport source (output valid, cmd, feedback, elapsed_us, filter_tau_us, measured_deriv,
                  input ready);
  modport sink (input valid, cmd, feedback, elapsed_us, filter_tau_us, measured_deriv,
                output ready);
endinterface

interface pidc_out_if import pidc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     out_clamped;
  logic                     integ_clamped;

  modport source (output valid, drive, out_clamped, integ_clamped, input ready);
  modport sink (input valid, drive, out_clamped, integ_clamped, output ready);
endinterface

### rtl/pidc_regs.sv
// APB-style configuration register file of the PID step block.
// Depends on pidc_pkg for cfg_t and register indexes.
`timescale 1ns / 1ps

module pidc_regs import pidc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_SETPOINT:    cfg_nxt.setpoint    = pwdata;
        REG_GAIN_P:      cfg_nxt.gain_p      = pwdata;
        REG_GAIN_I:      cfg_nxt.gain_i      = pwdata;
        REG_GAIN_D:      cfg_nxt.gain_d      = pwdata;
        REG_OUT_MAX:     cfg_nxt.out_max     = pwdata;
        REG_OUT_MIN:     cfg_nxt.out_min     = pwdata;
        REG_INTEG_LIMIT: cfg_nxt.integ_limit = pwdata[DATA_W-2:0];
        REG_DERIV_MODE:  cfg_nxt.deriv_mode  = dmode_t'(pwdata[1:0]);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SETPOINT:    prdata = cfg_r.setpoint;
      REG_GAIN_P:      prdata = cfg_r.gain_p;
      REG_GAIN_I:      prdata = cfg_r.gain_i;
      REG_GAIN_D:      prdata = cfg_r.gain_d;
      REG_OUT_MAX:     prdata = cfg_r.out_max;
      REG_OUT_MIN:     prdata = cfg_r.out_min;
      REG_INTEG_LIMIT: prdata = {1'b0, cfg_r.integ_limit};
      REG_DERIV_MODE:  prdata = {{(DATA_W-2){1'b0}}, cfg_r.deriv_mode};
      default:         prdata = '0;
    endcase
  end

endmodule

### rtl/pidc_mul.sv
// Bit-serial shift-add multiplier on unsigned magnitudes, one multiplier bit per cycle.
// Depends on pidc_pkg for widths and the status struct.
`timescale 1ns / 1ps

module pidc_mul import pidc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MAG_W-1:0]  a,
  input  logic [MAG_W-1:0]  b,
  output logic [PROD_W-1:0] prod,
  output unit_stat_t        stat
);

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]  mcand_r, mcand_nxt;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MAG_W:0]    sum;

  assign prod = p_r;
  assign stat = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r <= mcand_nxt;
    p_r     <= p_nxt;
  end

  always_comb begin
    sum       = {1'b0, p_r[PROD_W-1:MAG_W]} + (p_r[0] ? {1'b0, mcand_r} : '0);
    mcand_nxt = mcand_r;
    p_nxt     = p_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      mcand_nxt = a;
      p_nxt     = {{MAG_W{1'b0}}, b};
      cnt_nxt   = CNT_W'(MAG_W);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      // add on the low multiplier bit, then shift the partial product down
      p_nxt   = {sum, p_r[MAG_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

endmodule

### rtl/pidc_div.sv
// Bit-serial restoring divider on unsigned values, one quotient bit per cycle.
// Depends on pidc_pkg for widths and the status struct.
`timescale 1ns / 1ps

module pidc_div import pidc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QUO_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output unit_stat_t       stat
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [QUO_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;

  assign quo  = q_r;
  assign stat = '{busy: busy_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  always_comb begin
    shifted  = {rem_r, q_r[QUO_W-1]};
    diff     = {1'b0, shifted} - {2'b00, den_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // keep the trial difference only when it does not borrow
      if (!diff[DEN_W+1]) begin
        rem_nxt = diff[DEN_W-1:0];
        q_nxt   = {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DEN_W-1:0];
        q_nxt   = {q_r[QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

endmodule

### rtl/pid_controller_step.sv
// PID controller step on signed fixed-point values (FRAC_BITS fraction bits). Each
// accepted transaction either clears the stored state (cmd 1, result all zero) or
// runs one control step: error, trapezoid integral with clamp, one of four derivative
// terms, and the clamped PID sum. A sequencer drives one bit-serial multiplier and one
// bit-serial restoring divider in turn, so a step takes M multiplier passes and D
// divider passes: M = 5, D = 2 in error and measurement modes, M = 6, D = 3 in filtered
// mode, M = 4, D = 1 with an external derivative. A stalled output adds its stall to
// the step that waits on it. A new transaction is taken once the sequencer is idle,
// while the previous result may still wait in the output register. Depends on pidc_pkg,
// pidc_if, pidc_regs, pidc_mul, pidc_div and pid_controller_step_assert.svh.
`timescale 1ns / 1ps
`include "pid_controller_step_assert.svh"

module pid_controller_step import pidc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pidc_in_if.sink           in_ch,
  pidc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int DT_W  = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int ACC_W = PROD_W - FRAC_BITS;
  localparam int WID_W = QUO_W + 1;
  localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  cfg_t        cfg;
  unit_stat_t  mul_stat, div_stat;
  logic [PROD_W-1:0] mul_prod;
  logic [QUO_W-1:0]  div_quo;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [QUO_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              mul_start, div_start;

  state_t state_r, state_nxt;
  logic   launch_r, launch_nxt;

  logic signed [DATA_W-1:0] fb_r, fb_nxt;
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic [TIME_W-1:0]        tau_r, tau_nxt;
  logic signed [DATA_W-1:0] mder_r, mder_nxt;
  logic signed [DATA_W-1:0] err_r, err_nxt;
  logic signed [DATA_W-1:0] prev_err_r, prev_err_nxt;
  logic signed [DATA_W-1:0] err_int_r, err_int_nxt;
  logic signed [DATA_W-1:0] filt_r, filt_nxt;
  logic signed [DATA_W-1:0] prev_fb_r, prev_fb_nxt;
  logic signed [DATA_W-1:0] integ_new_r, integ_new_nxt;
  logic signed [DATA_W-1:0] d_r, d_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     iclamp_r, iclamp_nxt;
  logic signed [DATA_W-1:0] res_drive_r, res_drive_nxt;
  logic                     res_oc_r, res_oc_nxt;
  logic                     res_ic_r, res_ic_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] drive_r, drive_nxt;
  logic                     oc_out_r, oc_out_nxt;
  logic                     ic_out_r, ic_out_nxt;

  logic                     in_ready, in_take;
  logic [DT_W-1:0]          dt_raw;
  logic signed [MAG_W-1:0]  sp_dif, e_sum, e_dif, f_dif, r_dif;
  logic signed [DATA_W-1:0] err_sat;
  logic [DEN_W-1:0]         dt_den, ftau_den;
  logic                     meas_neg, op_neg;
  logic signed [WID_W-1:0]  q_s, itot, lim_w, nlim_w, fsum;
  logic [PROD_W-1:0]        prod_rnd;
  logic [ACC_W-1:0]         t_mag;
  logic signed [ACC_W-1:0]  term, omax, omin;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    logic signed [MAG_W-1:0] n;
    n = -v;
    return v[MAG_W-1] ? n : v;
  endfunction

  function automatic logic signed [MAG_W-1:0] sx(input logic signed [DATA_W-1:0] v);
    return {v[DATA_W-1], v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_w(input logic signed [WID_W-1:0] v);
    logic fits;
    fits = (v[WID_W-1:DATA_W-1] == '0) || (v[WID_W-1:DATA_W-1] == '1);
    if (fits) begin
      return v[DATA_W-1:0];
    end
    return v[WID_W-1] ? S_MIN : S_MAX;
  endfunction

  pidc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pidc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  pidc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  assign pready = 1'b1;

  assign in_ready            = (state_r == ST_IDLE);
  assign in_take             = in_ch.valid && in_ready;
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive        = drive_r;
  assign out_ch.out_clamped  = oc_out_r;
  assign out_ch.integ_clamped = ic_out_r;

  assign mul_start = launch_r && (state_r == ST_I_MUL || state_r == ST_D_MUL ||
                                  state_r == ST_F_MUL || state_r == ST_G_D ||
                                  state_r == ST_G_P || state_r == ST_G_I);
  assign div_start = launch_r && (state_r == ST_I_DIV || state_r == ST_D_DIV ||
                                  state_r == ST_F_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      err_int_r   <= '0;
      filt_r      <= '0;
      prev_fb_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      prev_err_r  <= prev_err_nxt;
      err_int_r   <= err_int_nxt;
      filt_r      <= filt_nxt;
      prev_fb_r   <= prev_fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fb_r        <= fb_nxt;
    dt_r        <= dt_nxt;
    tau_r       <= tau_nxt;
    mder_r      <= mder_nxt;
    err_r       <= err_nxt;
    integ_new_r <= integ_new_nxt;
    d_r         <= d_nxt;
    acc_r       <= acc_nxt;
    iclamp_r    <= iclamp_nxt;
    res_drive_r <= res_drive_nxt;
    res_oc_r    <= res_oc_nxt;
    res_ic_r    <= res_ic_nxt;
    drive_r     <= drive_nxt;
    oc_out_r    <= oc_out_nxt;
    ic_out_r    <= ic_out_nxt;
  end

  // datapath around the shared units
  always_comb begin
    dt_raw   = in_ch.elapsed_us[DT_W-1:0];
    sp_dif   = sx(cfg.setpoint) - sx(fb_r);
    if (sp_dif[MAG_W-1] != sp_dif[MAG_W-2]) begin
      err_sat = sp_dif[MAG_W-1] ? S_MIN : S_MAX;
    end else begin
      err_sat = sp_dif[DATA_W-1:0];
    end
    e_sum    = sx(err_r) + sx(prev_err_r);
    e_dif    = sx(err_r) - sx(prev_err_r);
    f_dif    = sx(fb_r) - sx(prev_fb_r);
    r_dif    = sx(d_r) - sx(filt_r);
    dt_den   = DEN_W'(dt_r);
    ftau_den = DEN_W'(tau_r) + DEN_W'(dt_r);
    meas_neg = (cfg.deriv_mode == DMODE_MEAS) || (cfg.deriv_mode == DMODE_EXT);

    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = TWO_MEGA;
    op_neg  = 1'b0;
    case (state_r)
      ST_I_MUL, ST_I_DIV: begin
        mul_a   = mag(e_sum);
        mul_b   = MAG_W'(dt_r);
        div_num = QUO_W'(mul_prod) + HALF_TWO_MEGA;
        div_den = TWO_MEGA;
        op_neg  = e_sum[MAG_W-1];
      end
      ST_D_MUL, ST_D_DIV: begin
        mul_a   = (cfg.deriv_mode == DMODE_MEAS) ? mag(f_dif) : mag(e_dif);
        mul_b   = USEC_PER_S;
        div_num = QUO_W'(mul_prod) + QUO_W'(dt_den >> 1);
        div_den = dt_den;
        op_neg  = (cfg.deriv_mode == DMODE_MEAS) ? f_dif[MAG_W-1] : e_dif[MAG_W-1];
      end
      ST_F_MUL, ST_F_DIV: begin
        mul_a   = mag(r_dif);
        mul_b   = MAG_W'(dt_r);
        div_num = QUO_W'(mul_prod) + QUO_W'(ftau_den >> 1);
        div_den = ftau_den;
        op_neg  = r_dif[MAG_W-1];
      end
      ST_G_D: begin
        mul_a  = mag(sx(cfg.gain_d));
        mul_b  = mag(sx(d_r));
        op_neg = cfg.gain_d[DATA_W-1] ^ d_r[DATA_W-1] ^ meas_neg;
      end
      ST_G_P: begin
        mul_a  = mag(sx(cfg.gain_p));
        mul_b  = mag(sx(err_r));
        op_neg = cfg.gain_p[DATA_W-1] ^ err_r[DATA_W-1];
      end
      ST_G_I: begin
        mul_a  = mag(sx(cfg.gain_i));
        mul_b  = mag(sx(integ_new_r));
        op_neg = cfg.gain_i[DATA_W-1] ^ integ_new_r[DATA_W-1];
      end
      default: begin
        op_neg = 1'b0;
      end
    endcase

    q_s    = op_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    itot   = $signed({{(WID_W-DATA_W){err_int_r[DATA_W-1]}}, err_int_r}) + q_s;
    lim_w  = $signed({{(WID_W-DATA_W+1){1'b0}}, cfg.integ_limit});
    nlim_w = -lim_w;
    fsum   = $signed({{(WID_W-DATA_W){filt_r[DATA_W-1]}}, filt_r}) + q_s;

    // round the product magnitude to nearest, ties away from zero
    prod_rnd = (mul_prod + RND_HALF) >> FRAC_BITS;
    t_mag    = prod_rnd[ACC_W-1:0];
    term     = op_neg ? -$signed(t_mag) : $signed(t_mag);
    omax     = $signed({{(ACC_W-DATA_W){cfg.out_max[DATA_W-1]}}, cfg.out_max});
    omin     = $signed({{(ACC_W-DATA_W){cfg.out_min[DATA_W-1]}}, cfg.out_min});
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    fb_nxt        = fb_r;
    dt_nxt        = dt_r;
    tau_nxt       = tau_r;
    mder_nxt      = mder_r;
    err_nxt       = err_r;
    prev_err_nxt  = prev_err_r;
    err_int_nxt   = err_int_r;
    filt_nxt      = filt_r;
    prev_fb_nxt   = prev_fb_r;
    integ_new_nxt = integ_new_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    iclamp_nxt    = iclamp_r;
    res_drive_nxt = res_drive_r;
    res_oc_nxt    = res_oc_r;
    res_ic_nxt    = res_ic_r;
    drive_nxt     = drive_r;
    oc_out_nxt    = oc_out_r;
    ic_out_nxt    = ic_out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          fb_nxt   = in_ch.feedback;
          dt_nxt   = (dt_raw == '0) ? DT_W'(1) : dt_raw;
          tau_nxt  = in_ch.filter_tau_us;
          mder_nxt = in_ch.measured_deriv;
          if (in_ch.cmd) begin
            prev_err_nxt  = '0;
            err_int_nxt   = '0;
            filt_nxt      = '0;
            prev_fb_nxt   = '0;
            res_drive_nxt = '0;
            res_oc_nxt    = 1'b0;
            res_ic_nxt    = 1'b0;
            state_nxt     = ST_OUT;
          end else begin
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        err_nxt    = err_sat;
        acc_nxt    = '0;
        iclamp_nxt = 1'b0;
        state_nxt  = ST_I_MUL;
        launch_nxt = 1'b1;
      end
      ST_I_MUL: begin
        if (mul_stat.done) begin
          state_nxt  = ST_I_DIV;
          launch_nxt = 1'b1;
        end
      end
      ST_I_DIV: begin
        if (div_stat.done) begin
          if (itot > lim_w) begin
            integ_new_nxt = lim_w[DATA_W-1:0];
            iclamp_nxt    = 1'b1;
          end else if (itot < nlim_w) begin
            integ_new_nxt = nlim_w[DATA_W-1:0];
            iclamp_nxt    = 1'b1;
          end else begin
            integ_new_nxt = itot[DATA_W-1:0];
          end
          if (cfg.deriv_mode == DMODE_EXT) begin
            d_nxt     = mder_r;
            state_nxt = ST_G_D;
          end else begin
            state_nxt = ST_D_MUL;
          end
          launch_nxt = 1'b1;
        end
      end
      ST_D_MUL: begin
        if (mul_stat.done) begin
          state_nxt  = ST_D_DIV;
          launch_nxt = 1'b1;
        end
      end
      ST_D_DIV: begin
        if (div_stat.done) begin
          d_nxt      = sat_w(q_s);
          state_nxt  = (cfg.deriv_mode == DMODE_FILT) ? ST_F_MUL : ST_G_D;
          launch_nxt = 1'b1;
        end
      end
      ST_F_MUL: begin
        if (mul_stat.done) begin
          state_nxt  = ST_F_DIV;
          launch_nxt = 1'b1;
        end
      end
      ST_F_DIV: begin
        if (div_stat.done) begin
          d_nxt      = sat_w(fsum);
          filt_nxt   = sat_w(fsum);
          state_nxt  = ST_G_D;
          launch_nxt = 1'b1;
        end
      end
      ST_G_D: begin
        if (mul_stat.done) begin
          acc_nxt    = acc_r + term;
          state_nxt  = ST_G_P;
          launch_nxt = 1'b1;
        end
      end
      ST_G_P: begin
        if (mul_stat.done) begin
          acc_nxt    = acc_r + term;
          state_nxt  = ST_G_I;
          launch_nxt = 1'b1;
        end
      end
      ST_G_I: begin
        if (mul_stat.done) begin
          acc_nxt   = acc_r + term;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        // upper bound first: inverted bounds give out_max if above it, else out_min
        if (acc_r > omax) begin
          res_drive_nxt = cfg.out_max;
          res_oc_nxt    = 1'b1;
        end else if (acc_r < omin) begin
          res_drive_nxt = cfg.out_min;
          res_oc_nxt    = 1'b1;
        end else begin
          res_drive_nxt = acc_r[DATA_W-1:0];
          res_oc_nxt    = 1'b0;
        end
        res_ic_nxt   = iclamp_r;
        prev_err_nxt = err_r;
        err_int_nxt  = integ_new_r;
        prev_fb_nxt  = fb_r;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          drive_nxt     = res_drive_r;
          oc_out_nxt    = res_oc_r;
          ic_out_nxt    = res_ic_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PIDC_ASSERT_SAME(a_idle_units, state_r == ST_IDLE, !mul_stat.busy && !div_stat.busy)
  `PIDC_ASSERT_NEXT(a_clear_out, in_take && in_ch.cmd, state_r == ST_OUT && res_drive_r == '0)
  `PIDC_ASSERT_NEXT(a_load_out, state_r == ST_OUT && (!out_valid_r || out_ch.ready), out_valid_r && state_r == ST_IDLE)

endmodule

### verif/pidc_step_checker.sv
// Transaction checker for the PID step block: snoops the register port, predicts each
// step result and compares it against the output channel. Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_step_checker import pidc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_cmd,
  input  logic [DATA_W-1:0] in_feedback,
  input  logic [TIME_W-1:0] in_elapsed_us,
  input  logic [TIME_W-1:0] in_filter_tau_us,
  input  logic [DATA_W-1:0] in_measured_deriv,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] out_drive,
  input  logic              out_clamped,
  input  logic              out_integ_clamped,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                errors,
  output int                pending,
  output int                results_seen
);

  typedef struct {
    logic [DATA_W-1:0] drive;
    logic              oclamp;
    logic              iclamp;
  } step_res_t;

  step_res_t drive_q[$];

  // register copies
  longint c_setpoint, c_kp, c_ki, c_kd, c_max, c_min, c_ilim;
  dmode_t c_mode;
  // loop state
  longint s_prev_err, s_integ, s_filt, s_prev_fb;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // divide by 2^FRAC_BITS, nearest, ties away from zero
  function automatic longint q_round(longint v);
    longint m;
    m = (abs64(v) + (64'sd1 <<< (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint div_near(longint num, longint den);
    longint m;
    m = (abs64(num) + den / 2) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic step_res_t pid_step(logic cmd, logic [DATA_W-1:0] fb_raw,
                                         logic [TIME_W-1:0] el, logic [TIME_W-1:0] tau_raw,
                                         logic [DATA_W-1:0] md_raw);
    step_res_t r;
    longint fb, err, dt, tau, sum, smag, q, rem, integ, d, raw, f, dterm, acc;
    r = '{default: '0};
    if (cmd) begin
      s_prev_err = 0; s_integ = 0; s_filt = 0; s_prev_fb = 0;
      return r;
    end
    fb  = longint'($signed(fb_raw));
    dt  = (el == 0) ? 1 : longint'(el);
    tau = longint'(tau_raw);
    err = sat32(c_setpoint - fb);
    sum  = err + s_prev_err;
    smag = abs64(sum);
    q    = smag / 2000000;
    rem  = smag % 2000000;
    integ = q * dt + (rem * dt + 1000000) / 2000000;
    integ = s_integ + ((sum < 0) ? -integ : integ);
    if (integ > c_ilim) begin
      integ = c_ilim; r.iclamp = 1'b1;
    end else if (integ < -c_ilim) begin
      integ = -c_ilim; r.iclamp = 1'b1;
    end
    case (c_mode)
      DMODE_ERR: begin
        d = sat32(div_near((err - s_prev_err) * 1000000, dt));
        dterm = q_round(c_kd * d);
      end
      DMODE_FILT: begin
        raw = sat32(div_near((err - s_prev_err) * 1000000, dt));
        f = sat32(s_filt + div_near((raw - s_filt) * dt, tau + dt));
        s_filt = f;
        dterm = q_round(c_kd * f);
      end
      DMODE_MEAS: begin
        d = sat32(div_near((fb - s_prev_fb) * 1000000, dt));
        dterm = -q_round(c_kd * d);
      end
      default: dterm = -q_round(c_kd * longint'($signed(md_raw)));
    endcase
    s_prev_err = err;
    s_integ    = integ;
    s_prev_fb  = fb;
    acc = q_round(c_kp * err) + q_round(c_ki * integ) + dterm;
    if (acc > c_max) begin
      acc = c_max; r.oclamp = 1'b1;
    end else if (acc < c_min) begin
      acc = c_min; r.oclamp = 1'b1;
    end
    r.drive = acc[DATA_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    step_res_t want;
    if (!rst_n) begin
      c_setpoint <= 0; c_kp <= 0; c_ki <= 0; c_kd <= 0;
      c_max <= 0; c_min <= 0; c_ilim <= 0; c_mode <= DMODE_ERR;
      s_prev_err = 0; s_integ = 0; s_filt = 0; s_prev_fb = 0;
      drive_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_SETPOINT:    c_setpoint <= longint'($signed(pwdata));
          REG_GAIN_P:      c_kp <= longint'($signed(pwdata));
          REG_GAIN_I:      c_ki <= longint'($signed(pwdata));
          REG_GAIN_D:      c_kd <= longint'($signed(pwdata));
          REG_OUT_MAX:     c_max <= longint'($signed(pwdata));
          REG_OUT_MIN:     c_min <= longint'($signed(pwdata));
          REG_INTEG_LIMIT: c_ilim <= longint'(pwdata[DATA_W-2:0]);
          REG_DERIV_MODE:  c_mode <= dmode_t'(pwdata[1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        drive_q.push_back(pid_step(in_cmd, in_feedback, in_elapsed_us, in_filter_tau_us,
                                   in_measured_deriv));
      if (out_valid && out_ready) begin
        results_seen++;
        if (drive_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, drive",
                          longint'($signed(out_drive)), 0);
        end else begin
          want = drive_q.pop_front();
          if (out_drive !== want.drive)
            report_mismatch("drive", longint'($signed(out_drive)),
                            longint'($signed(want.drive)));
          if (out_clamped !== want.oclamp)
            report_mismatch("out_clamped", out_clamped, want.oclamp);
          if (out_integ_clamped !== want.iclamp)
            report_mismatch("integ_clamped", out_integ_clamped, want.iclamp);
        end
      end
    end
    pending <= drive_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end

endmodule

### verif/tb_pid_controller_step.sv
// Top of the PID step testbench: clock, reset, register programming and step stimulus.
// Depends on pidc_pkg, pidc_if, the block itself and pidc_step_checker.
`timescale 1ns / 1ps

module tb_pid_controller_step;
  import pidc_pkg::*;

  localparam int  RAND_ITEMS = 1530;
  localparam int  PHASE_LEN  = 120;
  localparam int  TAIL_ITEMS = 150;
  localparam longint LIMIT   = 3_000_000;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic tail_run;
  int errors, pending, results_seen, sent, phases;
  longint cycles;

  pidc_in_if  in_ch();
  pidc_out_if out_ch();

  always #2 clk = ~clk;

  pid_controller_step uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pidc_step_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
    .in_feedback(in_ch.feedback), .in_elapsed_us(in_ch.elapsed_us),
    .in_filter_tau_us(in_ch.filter_tau_us), .in_measured_deriv(in_ch.measured_deriv),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_drive(out_ch.drive),
    .out_clamped(out_ch.out_clamped), .out_integ_clamped(out_ch.integ_clamped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // result-side back-pressure: random stall bursts, none in the tail
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || tail_run) begin
      out_ch.ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("pid_controller_step verification failed");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // hold off until the block has drained before touching the registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic load_gains(logic [DATA_W-1:0] sp, logic [DATA_W-1:0] kp,
                            logic [DATA_W-1:0] ki, logic [DATA_W-1:0] kd,
                            logic [DATA_W-1:0] omax, logic [DATA_W-1:0] omin,
                            logic [DATA_W-1:0] ilim, dmode_t mode);
    drain();
    reg_write(REG_SETPOINT, sp);
    reg_write(REG_GAIN_P, kp);
    reg_write(REG_GAIN_I, ki);
    reg_write(REG_GAIN_D, kd);
    reg_write(REG_OUT_MAX, omax);
    reg_write(REG_OUT_MIN, omin);
    reg_write(REG_INTEG_LIMIT, ilim);
    reg_write(REG_DERIV_MODE, {30'd0, mode});
    phases++;
  endtask

  task automatic send_step(logic cmd, logic [DATA_W-1:0] fb, logic [TIME_W-1:0] el,
                           logic [TIME_W-1:0] tau, logic [DATA_W-1:0] md);
    if (!tail_run && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.feedback <= fb;
    in_ch.elapsed_us <= el;
    in_ch.filter_tau_us <= tau;
    in_ch.measured_deriv <= md;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [DATA_W-1:0] pick_q16(int wide_pct);
    if ($urandom_range(0, 99) < wide_pct) return $urandom();
    return DATA_W'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {TIME_W{1'b1}};
      2:       return TIME_W'($urandom());
      default: return TIME_W'($urandom_range(1, 20000));
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] omax, omin;
    rst_n = 1'b0;
    cycles = 0;
    sent = 0;
    phases = 0;
    tail_run = 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.cmd <= 1'b0; in_ch.feedback <= '0;
    in_ch.elapsed_us <= '0; in_ch.filter_tau_us <= '0; in_ch.measured_deriv <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every derivative mode, field extremes, zero time, clear
    for (int m = 0; m < 4; m++) begin
      load_gains(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_0100,
                 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, dmode_t'(m));
      send_step(1'b0, 32'h8000_0000, '0, '0, 32'h7fff_ffff);
      send_step(1'b0, 32'h7fff_ffff, {TIME_W{1'b1}}, {TIME_W{1'b1}}, 32'h8000_0000);
      send_step(1'b0, 32'h0000_0000, 24'd1, '0, 32'h0001_0000);
      send_step(1'b0, 32'h0001_0000, 24'd1000, 24'd5000, 32'hffff_0000);
      send_step(1'b1, 32'hffff_ffff, {TIME_W{1'b1}}, {TIME_W{1'b1}}, 32'hffff_ffff);
    end
    // extreme gains, inverted clamp bounds, zero integral limit
    load_gains(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
               32'hffff_0000, 32'h0001_0000, 32'h0, DMODE_ERR);
    send_step(1'b0, 32'h7fff_ffff, 24'd1, '0, '0);
    send_step(1'b0, 32'h8000_0000, 24'd1, '0, '0);

    while (sent < 22 + RAND_ITEMS) begin
      omax = pick_q16(20);
      omin = pick_q16(20);
      if ($urandom_range(0, 3) != 0 && $signed(omin) > $signed(omax)) begin
        omax = omax ^ omin; omin = omax ^ omin; omax = omax ^ omin;
      end
      if ($urandom_range(0, 4) == 0) begin
        omax = 32'h7fff_ffff; omin = 32'h8000_0000;
      end
      load_gains(pick_q16(20), pick_q16(15), pick_q16(15), pick_q16(15), omax, omin,
                 ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 32'h0010_0000),
                 dmode_t'($urandom_range(0, 3)));
      for (int k = 0; k < PHASE_LEN && sent < 22 + RAND_ITEMS; k++) begin
        if (sent >= 22 + RAND_ITEMS - TAIL_ITEMS) tail_run = 1'b1;
        send_step(($urandom_range(0, 19) == 0), pick_q16(15), pick_time(),
                  ($urandom_range(0, 3) == 0) ? TIME_W'($urandom()) : pick_time(),
                  pick_q16(30));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("Sent %0d steps over %0d register settings in all four derivative modes;",
             sent, phases);
    $display("%0d results checked, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("pid_controller_step verification clean");
    end else begin
      $display("pid_controller_step verification failed");
    end
    $finish;
  end

endmodule
